@@ design/rtc_pkg.sv @@
package rtc_pkg;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register addresses
  localparam logic [7:0] ADDR_SEC   = 8'h00;
  localparam logic [7:0] ADDR_MIN   = 8'h01;
  localparam logic [7:0] ADDR_HOUR  = 8'h02;
  localparam logic [7:0] ADDR_WDAY  = 8'h03;
  localparam logic [7:0] ADDR_DAY   = 8'h04;
  localparam logic [7:0] ADDR_MONTH = 8'h05;
  localparam logic [7:0] ADDR_YEAR  = 8'h06;
  localparam logic [7:0] ADDR_RAM_LO = 8'h20;
  localparam logic [7:0] ADDR_RAM_HI = 8'h60;

  // battery-backed ram geometry
  localparam int unsigned RAM_BYTES = 64;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

  localparam logic [29:0] CPS_RESET = 30'd8000000;

  // binary to packed bcd, tens digit truncated to a nibble
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - ({3'd0, q} * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  // packed bcd to binary, nibbles taken at face value
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
  endfunction

  // days in the month, invalid months count as 31
  function automatic logic [7:0] month_days(input logic [7:0] mon, input logic leap);
    logic [7:0] d;
    case (mon)
      8'd2:    d = leap ? 8'd29 : 8'd28;
      8'd4:    d = 8'd30;
      8'd6:    d = 8'd30;
      8'd9:    d = 8'd30;
      8'd11:   d = 8'd30;
      default: d = 8'd31;
    endcase
    return d;
  endfunction

endpackage

@@ design/bcd_rtc_calendar_regs_unit.sv @@
// bcd real-time clock and calendar with 64 bytes of battery-backed ram
//
// input stream: s_axis_tuser holds the request kind (tick, read, write);
// s_axis_tdata holds reg_addr, write_data and tick_cycles. every accepted
// item gives exactly one result item on the master stream: read_data and
// the nvram_written flag.
// latency: the result is valid the cycle after the item is accepted. the
// block takes one item per cycle; the time registers are updated in the
// accept cycle and the ram is read through its registered port, so a read
// right after a write to the same byte sees the new value.
// cycles_per_second is written through cfg_we_i / cfg_wdata_i; the user must do this only
// while idle, as the block does not enforce it. reset: oscillator stopped, 24-hour mode,
// battery enable set, date 00-01-01 weekday 1, all ram bytes read as zero until written.
// stall: a result waiting on m_axis_tready holds in the output register;
// the input side accepts as long as that register is free or being taken.
module bcd_rtc_calendar_regs_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [29:0] cfg_wdata_i,   // cycles_per_second
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // reg_addr[7:0], write_data[15:8], tick_cycles[31:16]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_data[7:0], nvram_written[8], zero[15:9]
);

  localparam int unsigned AW = rtc_pkg::RAM_AW;

  // configuration and time state
  logic [29:0] cps_q;
  logic        osc_q, osc_d;
  logic        batt_q, batt_d;
  logic        m24_q, m24_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sec_q, sec_d;
  logic [7:0]  min_q, min_d;
  logic [7:0]  hour_q, hour_d;
  logic [3:0]  wd_q, wd_d;
  logic [7:0]  day_q, day_d;
  logic [7:0]  mon_q, mon_d;
  logic [7:0]  yr_q, yr_d;

  // ram, its valid bits and the output stage
  logic [7:0]           mem [rtc_pkg::RAM_BYTES];
  logic [rtc_pkg::RAM_BYTES-1:0] vld_q;
  logic [7:0]  rdata_q;
  logic        rvld_q;
  logic        ovld_q;
  logic        oram_q;
  logic [7:0]  ord_q, ord_d;
  logic        onv_q;

  // input decode
  logic [1:0]  kind;
  logic [7:0]  addr;
  logic [7:0]  wdat;
  logic [15:0] cyc;
  logic        in_acc;
  logic        ram_hit;
  logic [AW-1:0] ram_idx;
  logic        ram_wr;
  logic        ram_rd;

  assign kind    = s_axis_tuser;
  assign addr    = s_axis_tdata[7:0];
  assign wdat    = s_axis_tdata[15:8];
  assign cyc     = s_axis_tdata[31:16];
  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign ram_hit = (addr >= rtc_pkg::ADDR_RAM_LO) && (addr < rtc_pkg::ADDR_RAM_HI);
  assign ram_idx = addr[AW-1:0] - rtc_pkg::ADDR_RAM_LO[AW-1:0];
  assign ram_wr  = in_acc && (kind == rtc_pkg::REQ_WRITE) && ram_hit;
  assign ram_rd  = (kind == rtc_pkg::REQ_READ) && ram_hit;

  // tick accumulator
  logic [31:0] cps_eff;
  logic [31:0] acc_sum;
  logic        sec_carry;

  assign cps_eff   = (cps_q == '0) ? 32'd1 : {2'b00, cps_q};
  assign acc_sum   = acc_q + {16'd0, cyc};
  assign sec_carry = acc_sum >= cps_eff;

  // next time state: tick cascade or register write
  logic [7:0] inc_sec, inc_min, inc_hour, inc_day, inc_mon, inc_yr;
  logic [3:0] inc_wd;
  logic [7:0] wr_h;
  logic [7:0] wr_hraw;
  logic       wr_pm;
  logic       wr_12;

  always_comb begin
    osc_d  = osc_q;
    batt_d = batt_q;
    m24_d  = m24_q;
    acc_d  = acc_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    wd_d   = wd_q;
    day_d  = day_q;
    mon_d  = mon_q;
    yr_d   = yr_q;

    inc_sec  = sec_q + 8'd1;
    inc_min  = min_q + 8'd1;
    inc_hour = hour_q + 8'd1;
    inc_wd   = wd_q + 4'd1;
    inc_day  = day_q + 8'd1;
    inc_mon  = mon_q + 8'd1;
    inc_yr   = yr_q + 8'd1;

    wr_12   = wdat[6];
    wr_pm   = wr_12 && wdat[5];
    wr_hraw = rtc_pkg::from_bcd(wr_12 ? {3'd0, wdat[4:0]} : {2'd0, wdat[5:0]});
    wr_h    = (wr_12 && wr_hraw == 8'd12) ? 8'd0 : wr_hraw;
    if (wr_pm) begin
      wr_h = wr_h + 8'd12;
    end

    if (kind == rtc_pkg::REQ_TICK && osc_q) begin
      acc_d = sec_carry ? acc_sum - cps_eff : acc_sum;
      if (sec_carry) begin
        sec_d = inc_sec;
        if (inc_sec >= 8'd60) begin
          sec_d = 8'd0;
          min_d = inc_min;
          if (inc_min >= 8'd60) begin
            min_d  = 8'd0;
            hour_d = inc_hour;
            if (inc_hour >= 8'd24) begin
              hour_d = 8'd0;
              wd_d   = (inc_wd > 4'd7 || inc_wd == 4'd0) ? 4'd1 : inc_wd;
              day_d  = inc_day;
              if (inc_day > rtc_pkg::month_days(mon_q, yr_q[1:0] == 2'd0)) begin
                day_d = 8'd1;
                mon_d = inc_mon;
                if (inc_mon > 8'd12) begin
                  mon_d = 8'd1;
                  yr_d  = (inc_yr == 8'd100) ? 8'd0 : inc_yr;
                end
              end
            end
          end
        end
      end
    end else if (kind == rtc_pkg::REQ_WRITE) begin
      case (addr)
        rtc_pkg::ADDR_SEC: begin
          osc_d = wdat[7];
          sec_d = rtc_pkg::from_bcd({1'b0, wdat[6:0]});
        end
        rtc_pkg::ADDR_MIN:   min_d = rtc_pkg::from_bcd(wdat);
        rtc_pkg::ADDR_HOUR: begin
          m24_d  = !wr_12;
          hour_d = wr_h;
        end
        rtc_pkg::ADDR_WDAY: begin
          wd_d   = {1'b0, wdat[2:0]};
          batt_d = wdat[3];
        end
        rtc_pkg::ADDR_DAY:   day_d = rtc_pkg::from_bcd(wdat);
        rtc_pkg::ADDR_MONTH: mon_d = rtc_pkg::from_bcd(wdat);
        rtc_pkg::ADDR_YEAR:  yr_d  = rtc_pkg::from_bcd(wdat);
        default: ;
      endcase
    end
  end

  // register read value for non-ram addresses
  logic [7:0] rd_h;
  logic       rd_pm;

  always_comb begin
    rd_h  = hour_q;
    rd_pm = 1'b0;
    if (!m24_q) begin
      if (hour_q >= 8'd12) begin
        rd_pm = 1'b1;
        rd_h  = hour_q - 8'd12;
      end
      if (rd_h == 8'd0) begin
        rd_h = 8'd12;
      end
    end

    ord_d = 8'd0;
    if (kind == rtc_pkg::REQ_READ) begin
      case (addr)
        rtc_pkg::ADDR_SEC:   ord_d = rtc_pkg::to_bcd(sec_q) | {osc_q, 7'd0};
        rtc_pkg::ADDR_MIN:   ord_d = rtc_pkg::to_bcd(min_q);
        rtc_pkg::ADDR_HOUR:  ord_d = rtc_pkg::to_bcd(rd_h) | {1'b0, !m24_q, rd_pm, 5'd0};
        rtc_pkg::ADDR_WDAY:  ord_d = {4'd0, wd_q} | {2'd0, osc_q, 1'b0, batt_q, 3'd0};
        rtc_pkg::ADDR_DAY:   ord_d = rtc_pkg::to_bcd(day_q);
        rtc_pkg::ADDR_MONTH: ord_d = rtc_pkg::to_bcd(mon_q) | {2'd0, yr_q[1:0] == 2'd0, 5'd0};
        rtc_pkg::ADDR_YEAR:  ord_d = rtc_pkg::to_bcd(yr_q);
        default:             ord_d = (addr >= rtc_pkg::ADDR_RAM_HI) ? 8'hFF : 8'h00;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q  <= rtc_pkg::CPS_RESET;
      osc_q  <= 1'b0;
      batt_q <= 1'b1;
      m24_q  <= 1'b1;
      acc_q  <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      wd_q   <= 4'd1;
      day_q  <= 8'd1;
      mon_q  <= 8'd1;
      yr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cps_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        osc_q  <= osc_d;
        batt_q <= batt_d;
        m24_q  <= m24_d;
        acc_q  <= acc_d;
        sec_q  <= sec_d;
        min_q  <= min_d;
        hour_q <= hour_d;
        wd_q   <= wd_d;
        day_q  <= day_d;
        mon_q  <= mon_d;
        yr_q   <= yr_d;
      end
    end
  end

  // ram array with registered read port
  always_ff @(posedge clk_i) begin
    if (ram_wr) begin
      mem[ram_idx] <= wdat;
    end
    if (in_acc) begin
      rdata_q <= mem[ram_idx];
    end
  end

  // per-byte written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_wr) begin
      vld_q[ram_idx] <= 1'b1;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (in_acc) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ord_q  <= ord_d;
      oram_q <= ram_rd;
      onv_q  <= ram_wr;
      rvld_q <= vld_q[ram_idx];
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {7'd0, onv_q,
                          oram_q ? (rvld_q ? rdata_q : 8'd0) : ord_q};

  // a ram write marks its byte as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr |=> vld_q[$past(ram_idx)])
    else $error("ram byte not marked written");

  // every accepted item shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // a ram write never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("write result with nonzero read data");

endmodule
